// ----- hdl/dsf_pkg.sv -----
package dsf_pkg;

   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int INT_W       = 31;
   localparam int FRAC_ACC_W  = 30;
   localparam int COUNT_W     = 4;
   localparam int VALUE_W     = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam int FRAC_BITS_DEFAULT       = 32;
   localparam int MAX_FRAC_DIGITS_DEFAULT = 9;

   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'd46;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

   localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

   // one finished string, waiting for the fraction division
   typedef struct packed {
      logic                  negative;
      logic                  saturated;
      logic [INT_W-1:0]      int_acc;
      logic [FRAC_ACC_W-1:0] frac_acc;
      logic [COUNT_W-1:0]    digit_count;
   } job_type;

   function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [COUNT_W-1:0] n);
      logic [FRAC_ACC_W-1:0] p;
      unique case (n)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

// ----- hdl/dsf_req_if.sv -----
interface dsf_req_if import dsf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ----- hdl/dsf_rsp_if.sv -----
interface dsf_rsp_if import dsf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      overflowed;

   modport source (output valid, output value, output overflowed, input ready);
   modport sink (input valid, input value, input overflowed, output ready);
endinterface

// ----- hdl/decimal_string_to_fixed_point_top.sv -----
// Decimal text to signed fixed point (Q31.FRAC_BITS in a 64-bit word).
// req_chan takes one ASCII character per item, with end_of_text marking the
// last character of a string; rsp_chan gives one item (value, overflowed)
// per string, in string order. Both are valid/ready channels.
// The parser front end takes one character every cycle while the queue is
// not full. On the last character the parsed string goes into a two-entry
// queue and the parser restarts at once. The back end takes one string at a
// time; it divides the kept fraction digits by a power of ten one quotient
// bit per cycle, then rounds, adds the integer part and applies the sign.
// Sustained rate is one character per cycle as long as the back end keeps
// pace with the strings; otherwise the queue fills and req ready drops
// until the divider frees an entry.
// A stalled result stays in the output register; the divider finishes the
// next string and holds it until the register frees, while the queue keeps
// taking strings until it is full.
// Synchronous reset returns the parser to leading blanks and empties the
// queue and the output register.
module decimal_string_to_fixed_point_top import dsf_pkg::*; #(
   parameter int FRAC_BITS       = FRAC_BITS_DEFAULT,
   parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dsf_req_if.sink   req_chan,
   dsf_rsp_if.source rsp_chan
);

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   dsf_front #(
      .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   dsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   dsf_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_chan  (rsp_chan)
   );

   // the parser never hands over a string the queue cannot hold
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("string pushed into a full queue");

   // every accepted last character produces a queue entry
   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.end_of_text) |-> push_valid)
      else $error("end of string without a queue entry");

   // the divider takes one string at a time
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> !pop_ready)
      else $error("divider accepted a string while busy");

endmodule

// ----- hdl/dsf_front.sv -----
module dsf_front import dsf_pkg::*; #(
   parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dsf_req_if.sink   req_chan,
   input  logic      queue_full,
   output logic      push_valid,
   output job_type   push_job
);

   localparam logic [1:0] PH_BLANK = 2'd0;
   localparam logic [1:0] PH_INT   = 2'd1;
   localparam logic [1:0] PH_FRAC  = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic                  negative_ff, negative_in;
   logic                  saturated_ff, saturated_in;
   logic [INT_W-1:0]      int_acc_ff, int_acc_in;
   logic [FRAC_ACC_W-1:0] frac_acc_ff, frac_acc_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [CHAR_W-1:0]  c;
   logic [DIGIT_W-1:0] digit;
   logic               is_digit;
   logic               is_blank;
   logic [INT_W+3:0]   int_wide;
   logic               accept;

   assign c        = req_chan.char_code;
   assign digit    = c[DIGIT_W-1:0];
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   assign int_wide = ({4'b0, int_acc_ff} << 3) + ({4'b0, int_acc_ff} << 1)
                     + {{(INT_W){1'b0}}, digit};

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // state after this item, before the restart at the end of a string
   always_comb begin
      logic int_digit;
      logic frac_digit;
      int_digit    = 1'b0;
      frac_digit   = 1'b0;
      phase_in     = phase_ff;
      negative_in  = negative_ff;
      saturated_in = saturated_ff;
      int_acc_in   = int_acc_ff;
      frac_acc_in  = frac_acc_ff;
      count_in     = count_ff;
      unique case (phase_ff)
         PH_BLANK: begin
            priority if (is_blank) begin
               phase_in = PH_BLANK;
            end else if (c == CHAR_MINUS) begin
               negative_in = 1'b1;
               phase_in    = PH_INT;
            end else if (c == CHAR_PLUS) begin
               phase_in = PH_INT;
            end else if (is_digit) begin
               int_digit = 1'b1;
               phase_in  = PH_INT;
            end else if (c == CHAR_POINT) begin
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_INT: begin
            priority if (is_digit) begin
               int_digit = 1'b1;
            end else if (c == CHAR_POINT) begin
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               frac_digit = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
      endcase
      if (int_digit && !saturated_ff) begin
         if (int_wide > {4'b0, INT_MAX}) begin
            int_acc_in   = INT_MAX;
            saturated_in = 1'b1;
         end else begin
            int_acc_in = int_wide[INT_W-1:0];
         end
      end
      if (frac_digit && (count_ff < COUNT_W'(MAX_FRAC_DIGITS))) begin
         frac_acc_in = FRAC_ACC_W'((frac_acc_ff << 3) + (frac_acc_ff << 1)
                                   + {{(FRAC_ACC_W-DIGIT_W){1'b0}}, digit});
         count_in    = count_ff + 1'b1;
      end
   end

   assign push_valid           = accept && req_chan.end_of_text;
   assign push_job.negative    = negative_in;
   assign push_job.saturated   = saturated_in;
   assign push_job.int_acc     = int_acc_in;
   assign push_job.frac_acc    = frac_acc_in;
   assign push_job.digit_count = count_in;

   always_ff @(posedge clock) begin
      if (reset || push_valid) begin
         phase_ff     <= PH_BLANK;
         negative_ff  <= 1'b0;
         saturated_ff <= 1'b0;
         int_acc_ff   <= '0;
         frac_acc_ff  <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         saturated_ff <= saturated_in;
         int_acc_ff   <= int_acc_in;
         frac_acc_ff  <= frac_acc_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ----- hdl/dsf_queue.sv -----
module dsf_queue import dsf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (level_ff == LVL_W'(QUEUE_DEPTH));
   assign pop_valid = (level_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/dsf_back.sv -----
module dsf_back import dsf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  job_type   pop_job,
   dsf_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                state_ff, state_in;
   job_type                   job_ff, job_in;
   logic [FRAC_ACC_W-1:0]     rem_ff, rem_in;
   logic [FRAC_ACC_W-1:0]     div_ff, div_in;
   logic [FRAC_BITS-1:0]      quot_ff, quot_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      overflowed_ff, overflowed_in;

   logic [FRAC_ACC_W:0]  rem_shift;
   logic                 rem_ge;
   logic [FRAC_BITS:0]   quot_round;
   logic [FRAC_BITS-1:0] frac_bits;
   logic [VALUE_W-1:0]   magnitude;
   logic                 out_free;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});
   // after the last quotient bit, twice the remainder against the divisor decides rounding
   assign quot_round = {1'b0, quot_ff} + {{FRAC_BITS{1'b0}}, rem_ge};
   assign frac_bits  = quot_round[FRAC_BITS] ? {FRAC_BITS{1'b1}} : quot_round[FRAC_BITS-1:0];
   assign magnitude  = (VALUE_W'(job_ff.int_acc) << FRAC_BITS) | VALUE_W'(frac_bits);
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign pop_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quot_in       = quot_ff;
      cnt_in        = cnt_ff;
      value_in      = value_ff;
      overflowed_in = overflowed_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               job_in   = pop_job;
               rem_in   = pop_job.frac_acc;
               div_in   = pow10(pop_job.digit_count);
               quot_in  = '0;
               cnt_in   = CNT_W'(FRAC_BITS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, restoring
            if (rem_ge) begin
               rem_in = FRAC_ACC_W'(rem_shift - {1'b0, div_ff});
            end else begin
               rem_in = rem_shift[FRAC_ACC_W-1:0];
            end
            quot_in = {quot_ff[FRAC_BITS-2:0], rem_ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               value_in      = job_ff.negative ? -magnitude : magnitude;
               overflowed_in = job_ff.saturated;
               out_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quot_ff       <= quot_in;
      cnt_ff        <= cnt_in;
      value_ff      <= value_in;
      overflowed_ff <= overflowed_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.value      = value_ff;
   assign rsp_chan.overflowed = overflowed_ff;

endmodule
